// File: src/length_prefixed_message_queue_top_macros.svh
// Assertion macros for the message queue. Each expects clk and rst_n in scope.
`ifndef LENGTH_PREFIXED_MESSAGE_QUEUE_TOP_MACROS_SVH
`define LENGTH_PREFIXED_MESSAGE_QUEUE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPMQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpmq assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LPMQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpmq assertion failed");

`endif

// File: src/lpmq_pkg.sv
package lpmq_pkg;

  localparam int DEPTH_DEF  = 512;
  localparam int HDR_BYTES  = 4;
  localparam int LEN_W      = 32;
  localparam int MLEN_W     = 10;
  localparam int BYTE_W     = 8;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_BYTE     = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_STORED   = 3'd2,
    ST_FULL     = 3'd3,
    ST_OVERSIZE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HDR,
    S_PDATA
  } state_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [BYTE_W-1:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    status_t           status;
    logic              last_byte;
    logic [MLEN_W-1:0] msg_length;
    logic [MLEN_W-1:0] fill_level;
  } out_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;
  } q_item_t;

endpackage

// File: src/lpmq_front.sv
module lpmq_front
  import lpmq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  in_t     in_data,
  output logic    q_valid,
  output q_item_t q_item,
  input  logic    q_pop
);

  q_item_t     entries_r [2];
  logic        wr_idx_r;
  logic        wr_idx_nxt;
  logic        rd_idx_r;
  logic        rd_idx_nxt;
  logic [1:0]  cnt_r;
  logic [1:0]  cnt_nxt;
  logic        push;
  q_item_t     item_in;

  always_comb begin
    item_in.data = in_data.data_byte;
    unique case (in_data.cmd)
      CMD_PUSH: item_in.op = OP_PUSH;
      CMD_POP:  item_in.op = OP_POP;
      default:  item_in.op = OP_POP;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = entries_r[rd_idx_r];

  always_comb begin
    wr_idx_nxt = push  ? ~wr_idx_r : wr_idx_r;
    rd_idx_nxt = q_pop ? ~rd_idx_r : rd_idx_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= 1'b0;
      rd_idx_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_idx_r] <= item_in;
    end
  end

endmodule

// File: src/lpmq_back.sv
module lpmq_back
  import lpmq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    cfg_wr_en,
  input  logic    cfg_wr_data,
  input  logic    q_valid,
  input  q_item_t q_item,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_stall,
  output out_t    out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [1:0] HDR_LAST = 2'(HDR_BYTES - 1);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  state_t            state_r;
  state_t            state_nxt;
  logic [AW-1:0]     rd_ptr_r;
  logic [AW-1:0]     rd_ptr_nxt;
  logic [AW-1:0]     wr_ptr_r;
  logic [AW-1:0]     wr_ptr_nxt;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic [CW-1:0]     pending_r;
  logic [CW-1:0]     pending_nxt;
  logic [CW-1:0]     bytes_left_r;
  logic [CW-1:0]     bytes_left_nxt;
  logic              hdr_taken_r;
  logic              hdr_taken_nxt;
  logic              hdr_be_r;
  logic              hdr_be_nxt;
  logic [1:0]        hdr_cnt_r;
  logic [1:0]        hdr_cnt_nxt;
  logic [LEN_W-1:0]  len_acc_r;
  logic [LEN_W-1:0]  len_acc_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  out_t              out_data_r;
  out_t              out_data_nxt;

  logic              mem_we;
  logic              emit;
  out_t              res;
  logic              slot_free;
  logic              go;
  logic              is_push;
  logic              ring_full;
  logic              start_hdr;
  logic              pay_ready;
  logic [LEN_W-1:0]  len_full;
  logic              hdr_big;
  logic              hdr_zero;
  logic [CW-1:0]     len_c;
  logic              hdr_pay_ready;
  logic              hdr_done;
  logic [MLEN_W-1:0] mlen_cur;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign slot_free     = !out_valid_r || !out_stall;
  assign go            = q_valid && slot_free;
  assign is_push       = (q_item.op == OP_PUSH);
  assign ring_full     = (count_r == CW'(DEPTH));
  assign start_hdr     = !hdr_taken_r && (count_r >= CW'(HDR_BYTES));
  assign pay_ready     = hdr_taken_r && (bytes_left_r != '0) && (count_r >= bytes_left_r);
  assign len_full      = hdr_be_r ? {len_acc_r[LEN_W-BYTE_W-1:0], rd_data_r}
                                  : {rd_data_r, len_acc_r[LEN_W-1:BYTE_W]};
  assign hdr_big       = (len_full > LEN_W'(DEPTH));
  assign hdr_zero      = (len_full == '0);
  assign len_c         = CW'(len_full);
  assign hdr_pay_ready = (count_r >= len_c);
  assign hdr_done      = (hdr_cnt_r == HDR_LAST);
  assign mlen_cur      = hdr_taken_r ? MLEN_W'(pending_r) : '0;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (go && !is_push) begin
          if (start_hdr) begin
            state_nxt = S_HDR;
          end else if (pay_ready) begin
            state_nxt = S_PDATA;
          end
        end
      end
      S_HDR: begin
        if (hdr_done) begin
          if (!hdr_big && !hdr_zero && hdr_pay_ready) begin
            state_nxt = S_PDATA;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_PDATA: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    count_nxt      = count_r;
    pending_nxt    = pending_r;
    bytes_left_nxt = bytes_left_r;
    hdr_taken_nxt  = hdr_taken_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    len_acc_nxt    = len_acc_r;
    hdr_be_nxt     = cfg_wr_en ? cfg_wr_data : hdr_be_r;
    mem_we         = 1'b0;
    q_pop          = 1'b0;
    emit           = 1'b0;
    res.out_byte   = '0;
    res.status     = ST_EMPTY;
    res.last_byte  = 1'b0;
    res.msg_length = mlen_cur;
    res.fill_level = MLEN_W'(count_r);
    unique case (state_r)
      S_IDLE: begin
        if (go) begin
          if (is_push) begin
            emit  = 1'b1;
            q_pop = 1'b1;
            if (ring_full) begin
              res.status = ST_FULL;
            end else begin
              mem_we         = 1'b1;
              wr_ptr_nxt     = ptr_inc(wr_ptr_r);
              count_nxt      = count_r + 1'b1;
              res.status     = ST_STORED;
              res.fill_level = MLEN_W'(count_r + 1'b1);
            end
          end else if (start_hdr) begin
            rd_ptr_nxt  = ptr_inc(rd_ptr_r);
            count_nxt   = count_r - 1'b1;
            hdr_cnt_nxt = '0;
          end else if (pay_ready) begin
            rd_ptr_nxt = ptr_inc(rd_ptr_r);
            count_nxt  = count_r - 1'b1;
          end else begin
            emit  = 1'b1;
            q_pop = 1'b1;
          end
        end
      end
      S_HDR: begin
        if (!hdr_done) begin
          len_acc_nxt = len_full;
          hdr_cnt_nxt = hdr_cnt_r + 1'b1;
          rd_ptr_nxt  = ptr_inc(rd_ptr_r);
          count_nxt   = count_r - 1'b1;
        end else if (hdr_big) begin
          emit           = 1'b1;
          q_pop          = 1'b1;
          res.status     = ST_OVERSIZE;
          res.msg_length = '0;
        end else if (hdr_zero) begin
          emit           = 1'b1;
          q_pop          = 1'b1;
          res.msg_length = '0;
        end else begin
          hdr_taken_nxt  = 1'b1;
          pending_nxt    = len_c;
          bytes_left_nxt = len_c;
          if (hdr_pay_ready) begin
            rd_ptr_nxt = ptr_inc(rd_ptr_r);
            count_nxt  = count_r - 1'b1;
          end else begin
            emit           = 1'b1;
            q_pop          = 1'b1;
            res.msg_length = MLEN_W'(len_c);
          end
        end
      end
      S_PDATA: begin
        emit           = 1'b1;
        q_pop          = 1'b1;
        res.status     = ST_BYTE;
        res.out_byte   = rd_data_r;
        res.last_byte  = (bytes_left_r == CW'(1));
        res.msg_length = MLEN_W'(pending_r);
        bytes_left_nxt = bytes_left_r - 1'b1;
        if (bytes_left_r == CW'(1)) begin
          hdr_taken_nxt = 1'b0;
          pending_nxt   = '0;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    out_valid_nxt = emit || (out_valid_r && out_stall);
    out_data_nxt  = emit ? res : out_data_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rd_ptr_r     <= '0;
      wr_ptr_r     <= '0;
      count_r      <= '0;
      pending_r    <= '0;
      bytes_left_r <= '0;
      hdr_taken_r  <= 1'b0;
      hdr_be_r     <= 1'b1;
      hdr_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      count_r      <= count_nxt;
      pending_r    <= pending_nxt;
      bytes_left_r <= bytes_left_nxt;
      hdr_taken_r  <= hdr_taken_nxt;
      hdr_be_r     <= hdr_be_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_acc_r  <= len_acc_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr_r] <= q_item.data;
    end
    rd_data_r <= mem[rd_ptr_r];
  end

endmodule

// File: src/length_prefixed_message_queue_top.sv
// Byte ring buffer of DEPTH entries that releases length-prefixed messages. A push word
// stores one byte (or reports the ring full); a pop word takes a four-byte length header
// when none is pending and releases one payload byte once the whole payload is buffered.
// A two-word input queue decouples the input from the ring sequencer, and the result sits
// in an output register, so both sides can stall independently. The ring memory has a
// single registered read port, so a word steps through sequencer states: a push, or a
// pop that releases nothing, ends in S_IDLE; a pop that releases a byte of a pending
// message passes S_IDLE and S_PDATA; one that takes a header passes S_IDLE, S_HDR and,
// if it also releases the first byte, S_PDATA. No clearing pass is needed after reset.
`include "length_prefixed_message_queue_top_macros.svh"

module length_prefixed_message_queue_top
  import lpmq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic    q_valid;
  q_item_t q_item;
  logic    q_pop;

  lpmq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  lpmq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  `LPMQ_ASSERT_SAME(a_pop_needs_word, q_pop, q_valid)
  `LPMQ_ASSERT_NEXT(a_pop_gives_result, q_pop, out_valid)
  `LPMQ_ASSERT_SAME(a_byte_only_on_give, out_valid && (out_data.status != ST_BYTE), (out_data.out_byte == '0) && !out_data.last_byte)
  `LPMQ_ASSERT_SAME(a_oversize_no_len, out_valid && (out_data.status == ST_OVERSIZE), out_data.msg_length == '0)

endmodule
